// File: src/assert_macros.svh
// assertion macros shared by the length-prefixed message fifo rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, ck, rn, cond, msg)
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// File: src/lpmf_pkg.sv
// shared constants, request and status codes and the result beat type
`timescale 1ns / 1ps

package lpmf_pkg;

    localparam int STORE_BYTES_DEF = 256;

    typedef logic [2:0] req_code_t;
    localparam req_code_t REQ_RESET  = 3'd0;
    localparam req_code_t REQ_START  = 3'd1;
    localparam req_code_t REQ_APPEND = 3'd2;
    localparam req_code_t REQ_DATA   = 3'd3;
    localparam req_code_t REQ_READ   = 3'd4;
    localparam req_code_t REQ_REMOVE = 3'd5;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_TOO_BIG  = 3'd1;
    localparam status_t ST_NO_SPACE = 3'd2;
    localparam status_t ST_EMPTY    = 3'd3;
    localparam status_t ST_NO_WRITE = 3'd4;

    typedef struct packed {
        status_t    status;
        logic       last_of_entry;
        logic [8:0] free_space;
        logic [7:0] entry_count;
        logic [7:0] first_size;
        logic       rd_ok;
    } result_t;

endpackage

// File: src/lpmf_store.sv
// byte ring memory: one write port, a data read port and a header prefetch port
`timescale 1ns / 1ps

module lpmf_store
    import lpmf_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    localparam int AW = $clog2(STORE_BYTES)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic [AW-1:0] nh_addr,
    output logic [7:0]    nh_data
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_data_reg;
    logic [7:0] nh_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        // bypass a header written in this cycle at the prefetch address
        if (wr_en && (wr_addr == nh_addr))
        begin
            nh_data_reg <= wr_data;
        end
        else
        begin
            nh_data_reg <= mem[nh_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign nh_data = nh_data_reg;

endmodule

// File: src/lpmf_ctrl.sv
// ring pointers, counts, header shadows and the registered result beat
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpmf_ctrl
    import lpmf_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    localparam int AW = $clog2(STORE_BYTES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    req_type,
    input  logic [7:0]    entry_len,
    input  logic [7:0]    data_byte,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] nh_addr,
    input  logic [7:0]    nh_data,
    output logic          done,
    output result_t       res
);

    localparam logic [9:0] SIZE10 = 10'(STORE_BYTES);

    function automatic logic [9:0] ring_wrap(input logic [9:0] sum);
        return (sum >= SIZE10) ? (sum - SIZE10) : sum;
    endfunction

    logic          ready_reg;
    logic          accept;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] lhp_reg, lhp_next;
    logic [8:0]    used_reg, used_next;
    logic [7:0]    entries_reg, entries_next;
    logic [7:0]    wr_rem_reg, wr_rem_next;
    logic [7:0]    offset_reg, offset_next;
    logic [7:0]    first_hdr_reg, first_hdr_next;
    logic [7:0]    last_hdr_reg, last_hdr_next;
    logic          done_reg;
    result_t       res_reg, res_next;

    logic [9:0]    len10;
    logic [9:0]    used10;
    logic          too_big;
    logic [AW-1:0] base_pos;
    logic [7:0]    app_hdr;
    logic [AW-1:0] data_pos;
    logic [9:0]    hdr_p1;
    logic [AW-1:0] drop_pos;
    logic [8:0]    drop_used;
    logic [7:0]    offset_inc;
    logic          drop;
    status_t       st;
    logic          last;
    logic          rd_ok;

    assign accept = start && ready_reg;
    assign busy   = !ready_reg;
    assign rd_en  = accept;

    assign len10      = 10'(entry_len);
    assign used10     = 10'(used_reg);
    assign too_big    = (len10 + 10'd1) > SIZE10;
    assign base_pos   = (used_reg == 9'd0) ? '0 : tail_reg;
    assign app_hdr    = last_hdr_reg + entry_len;
    assign data_pos   = AW'(ring_wrap(10'(tail_reg) + SIZE10 - 10'(wr_rem_reg)));
    assign hdr_p1     = 10'(first_hdr_reg) + 10'd1;
    assign drop_pos   = AW'(ring_wrap(10'(head_reg) + hdr_p1));
    assign drop_used  = (used10 >= hdr_p1) ? 9'(used10 - hdr_p1) : 9'd0;
    assign offset_inc = offset_reg + 8'd1;
    assign rd_addr    = AW'(ring_wrap(10'(head_reg) + 10'(offset_reg) + 10'd1));

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        lhp_next       = lhp_reg;
        used_next      = used_reg;
        entries_next   = entries_reg;
        wr_rem_next    = wr_rem_reg;
        offset_next    = offset_reg;
        first_hdr_next = first_hdr_reg;
        last_hdr_next  = last_hdr_reg;
        st             = ST_OK;
        last           = 1'b0;
        rd_ok          = 1'b0;
        drop           = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = lhp_reg;
        wr_data        = app_hdr;

        if (accept)
        begin
            unique case (req_type)
                REQ_RESET:
                begin
                    head_next      = '0;
                    tail_next      = '0;
                    lhp_next       = '0;
                    used_next      = '0;
                    entries_next   = '0;
                    wr_rem_next    = '0;
                    offset_next    = '0;
                    first_hdr_next = '0;
                    last_hdr_next  = '0;
                    wr_en          = 1'b1;
                    wr_addr        = '0;
                    wr_data        = 8'd0;
                end
                REQ_START:
                begin
                    priority if (too_big)
                    begin
                        st = ST_TOO_BIG;
                    end
                    else if ((used10 + len10 + 10'd1) >= SIZE10)
                    begin
                        st = ST_NO_SPACE;
                    end
                    else
                    begin
                        // an empty ring restarts at position zero
                        if (used_reg == 9'd0)
                        begin
                            head_next   = '0;
                            offset_next = '0;
                        end
                        lhp_next      = base_pos;
                        tail_next     = AW'(ring_wrap(10'(base_pos) + len10 + 10'd1));
                        used_next     = 9'(used10 + len10 + 10'd1);
                        entries_next  = entries_reg + 8'd1;
                        wr_rem_next   = entry_len;
                        last_hdr_next = entry_len;
                        if (entries_reg == 8'd0)
                        begin
                            first_hdr_next = entry_len;
                        end
                        wr_en   = 1'b1;
                        wr_addr = base_pos;
                        wr_data = entry_len;
                    end
                end
                REQ_APPEND:
                begin
                    priority if (too_big)
                    begin
                        st = ST_TOO_BIG;
                    end
                    else if ((used10 + len10) >= SIZE10)
                    begin
                        st = ST_NO_SPACE;
                    end
                    else if (entries_reg == 8'd0)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        tail_next     = AW'(ring_wrap(10'(tail_reg) + len10));
                        used_next     = 9'(used10 + len10);
                        wr_rem_next   = wr_rem_reg + entry_len;
                        last_hdr_next = app_hdr;
                        if (entries_reg == 8'd1)
                        begin
                            first_hdr_next = app_hdr;
                        end
                        wr_en   = 1'b1;
                        wr_addr = lhp_reg;
                        wr_data = app_hdr;
                    end
                end
                REQ_DATA:
                begin
                    if (wr_rem_reg == 8'd0)
                    begin
                        st = ST_NO_WRITE;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = data_pos;
                        wr_data     = data_byte;
                        wr_rem_next = wr_rem_reg - 8'd1;
                    end
                end
                REQ_READ:
                begin
                    priority if (entries_reg == 8'd0)
                    begin
                        st = ST_EMPTY;
                    end
                    else if (first_hdr_reg == 8'd0)
                    begin
                        // zero-length entry: freed on its first read
                        last = 1'b1;
                        drop = 1'b1;
                    end
                    else
                    begin
                        rd_ok       = 1'b1;
                        offset_next = offset_inc;
                        if (offset_inc >= first_hdr_reg)
                        begin
                            last = 1'b1;
                            drop = 1'b1;
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (entries_reg == 8'd0)
                    begin
                        st = ST_EMPTY;
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // free the first entry and promote the prefetched header
            if (drop)
            begin
                head_next    = drop_pos;
                used_next    = drop_used;
                entries_next = entries_reg - 8'd1;
                offset_next  = 8'd0;
                if (entries_reg == 8'd1)
                begin
                    wr_rem_next    = 8'd0;
                    first_hdr_next = 8'd0;
                end
                else
                begin
                    first_hdr_next = nh_data;
                end
            end
        end
    end

    // header of the entry after the first, as it stands after this beat
    assign nh_addr = AW'(ring_wrap(10'(head_next) + 10'(first_hdr_next) + 10'd1));

    always_comb
    begin
        res_next.status        = st;
        res_next.last_of_entry = last;
        res_next.free_space    = 9'(SIZE10 - 10'(used_next));
        res_next.entry_count   = entries_next;
        res_next.first_size    = (entries_next == 8'd0) ? 8'd0 : first_hdr_next;
        res_next.rd_ok         = rd_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg     <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            lhp_reg       <= '0;
            used_reg      <= '0;
            entries_reg   <= '0;
            wr_rem_reg    <= '0;
            offset_reg    <= '0;
            first_hdr_reg <= '0;
            last_hdr_reg  <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            ready_reg     <= 1'b1;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            lhp_reg       <= lhp_next;
            used_reg      <= used_next;
            entries_reg   <= entries_next;
            wr_rem_reg    <= wr_rem_next;
            offset_reg    <= offset_next;
            first_hdr_reg <= first_hdr_next;
            last_hdr_reg  <= last_hdr_next;
            done_reg      <= accept;
            if (accept)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    `ASSERT_NEXT(a_one_result, clk, rst_n, accept, done_reg, "accepted beat gave no result")
    `ASSERT_NEXT(a_no_extra, clk, rst_n, !accept, !done_reg, "result without an accepted beat")
    `ASSERT_ALWAYS(a_used_bound, clk, rst_n, 10'(used_reg) < SIZE10, "ring byte count overflow")
    `ASSERT_IMPLIES(a_empty_clean, clk, rst_n, entries_reg == 8'd0, (used_reg == 9'd0) && (wr_rem_reg == 8'd0), "no entries but bytes held")
    `ASSERT_IMPLIES(a_last_ok, clk, rst_n, done_reg && res_reg.last_of_entry, res_reg.status == ST_OK, "entry end flagged on a failed beat")

endmodule

// File: src/length_prefixed_message_fifo.sv
// top level of the length-prefixed message fifo
`timescale 1ns / 1ps

// a ring of STORE_BYTES bytes that holds messages in arrival order, each as
// a length header byte followed by its data bytes. a beat is taken at a
// rising edge with start high and busy low; busy is high only until ready is
// registered after reset, so a beat can be taken in every cycle after. each
// beat gives exactly one result beat, marked by done in the cycle after it
// is taken and present for that one cycle only: the receiver cannot stall,
// so it must capture every result beat when done is high. one beat per cycle
// is set by the single write port and the registered data read of the byte
// ring; header sizes are shadowed in registers and the header of the next
// entry is prefetched every cycle through a second read port, so reads and
// removes run back to back. the ring needs no clearing pass after reset
module length_prefixed_message_fifo
    import lpmf_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    localparam int AW = $clog2(STORE_BYTES)
)
(
    input  logic       clk,
    input  logic       rst_n,
    // request beat
    input  logic       start,
    output logic       busy,
    input  logic [2:0] req_type,
    input  logic [7:0] entry_len,
    input  logic [7:0] data_byte,
    // result beat
    output logic       done,
    output logic [2:0] status,
    output logic [7:0] read_byte,
    output logic       last_of_entry,
    output logic [8:0] free_space,
    output logic [7:0] entry_count,
    output logic [7:0] first_size
);

    // ring write and read ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    // next-header prefetch
    logic [AW-1:0] nh_addr;
    logic [7:0]    nh_data;
    // registered result beat
    result_t       res;

    // pointers, counts, checks and the result register
    lpmf_ctrl #(
        .STORE_BYTES (STORE_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .entry_len (entry_len),
        .data_byte (data_byte),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .nh_addr   (nh_addr),
        .nh_data   (nh_data),
        .done      (done),
        .res       (res)
    );

    // byte ring, headers and data in one array
    lpmf_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .nh_addr (nh_addr),
        .nh_data (nh_data)
    );

    // the popped byte shows only on a read that returned data
    assign read_byte     = res.rd_ok ? rd_data : 8'd0;
    assign status        = res.status;
    assign last_of_entry = res.last_of_entry;
    assign free_space    = res.free_space;
    assign entry_count   = res.entry_count;
    assign first_size    = res.first_size;

endmodule

// File: bench/lpmf_tb_pkg.sv
// reply type and message ring tracker for the length-prefixed message fifo bench
`timescale 1ns / 1ps

package lpmf_tb_pkg;
    import lpmf_pkg::*;

    localparam int RING_BYTES = STORE_BYTES_DEF;

    // the two request codes that do nothing
    localparam req_code_t REQ_NOP_A = 3'd6;
    localparam req_code_t REQ_NOP_B = 3'd7;

    typedef struct packed {
        status_t    status;
        logic [7:0] read_byte;
        logic       last_of_entry;
        logic [8:0] free_space;
        logic [7:0] entry_count;
        logic [7:0] first_size;
    } reply_t;

    class msg_ring_tracker;
        logic [7:0]  ring [RING_BYTES];
        bit          ring_written [RING_BYTES];
        int unsigned head;
        int unsigned tail;
        int unsigned last_hdr;
        int unsigned used;
        int unsigned n_entries;
        int unsigned wr_left;
        int unsigned rd_off;
        reply_t      replies_due [$];
        int          errors;

        function new();
            clear_positions();
            errors = 0;
        endfunction

        function void clear_positions();
            head      = 0;
            tail      = 0;
            last_hdr  = 0;
            used      = 0;
            n_entries = 0;
            wr_left   = 0;
            rd_off    = 0;
        endfunction

        function void drop_first();
            int unsigned span;
            span      = int'(ring[head]) + 1;
            head      = (head + span) % RING_BYTES;
            used      = (used >= span) ? used - span : 0;
            n_entries = (n_entries - 1) & 8'hFF;
            rd_off    = 0;
            if (n_entries == 0)
                wr_left = 0;
        endfunction

        // a read must never land on a ring byte that was never written
        function bit read_is_safe();
            if (n_entries == 0 || ring[head] == 8'd0)
                return 1'b1;
            return ring_written[(head + 1 + rd_off) % RING_BYTES];
        endfunction

        function reply_t serve_request(req_code_t req, logic [7:0] len, logic [7:0] dat);
            reply_t      r;
            int unsigned hdr;
            int unsigned pos;
            r = '0;
            r.status = ST_OK;
            case (req)
                REQ_RESET:
                begin
                    clear_positions();
                    ring[0] = 8'h00;
                    ring_written[0] = 1'b1;
                end
                REQ_START:
                begin
                    if (int'(len) + 1 > RING_BYTES)
                        r.status = ST_TOO_BIG;
                    else if (used + len + 1 >= RING_BYTES)
                        r.status = ST_NO_SPACE;
                    else
                    begin
                        if (used == 0)
                        begin
                            head     = 0;
                            tail     = 0;
                            last_hdr = 0;
                            rd_off   = 0;
                        end
                        last_hdr = tail;
                        ring[last_hdr] = len;
                        ring_written[last_hdr] = 1'b1;
                        tail      = (tail + len + 1) % RING_BYTES;
                        used      = used + len + 1;
                        n_entries = (n_entries + 1) & 8'hFF;
                        wr_left   = 32'(len);
                    end
                end
                REQ_APPEND:
                begin
                    if (int'(len) + 1 > RING_BYTES)
                        r.status = ST_TOO_BIG;
                    else if (used + len >= RING_BYTES)
                        r.status = ST_NO_SPACE;
                    else if (n_entries == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        ring[last_hdr] = ring[last_hdr] + len;
                        tail    = (tail + len) % RING_BYTES;
                        used    = used + len;
                        wr_left = (wr_left + len) & 8'hFF;
                    end
                end
                REQ_DATA:
                begin
                    if (wr_left == 0)
                        r.status = ST_NO_WRITE;
                    else
                    begin
                        pos = (tail + RING_BYTES - wr_left) % RING_BYTES;
                        ring[pos] = dat;
                        ring_written[pos] = 1'b1;
                        wr_left = wr_left - 1;
                    end
                end
                REQ_READ:
                begin
                    if (n_entries == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        hdr = 32'(ring[head]);
                        if (hdr == 0)
                        begin
                            r.last_of_entry = 1'b1;
                            drop_first();
                        end
                        else
                        begin
                            pos = (head + 1 + rd_off) % RING_BYTES;
                            r.read_byte = ring[pos];
                            rd_off = (rd_off + 1) & 8'hFF;
                            if (rd_off >= hdr)
                            begin
                                r.last_of_entry = 1'b1;
                                drop_first();
                            end
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (n_entries == 0)
                        r.status = ST_EMPTY;
                    else
                        drop_first();
                end
                default: ;
            endcase
            r.free_space  = 9'(RING_BYTES - used);
            r.entry_count = 8'(n_entries);
            r.first_size  = (n_entries == 0) ? 8'd0 : ring[head];
            return r;
        endfunction

        function void take_request(req_code_t req, logic [7:0] len, logic [7:0] dat);
            replies_due.push_back(serve_request(req, len, dat));
        endfunction

        // four-state compare so an unknown on a result port counts as a mismatch
        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: result beat with none due, status %0d", $time, got.status);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
            compare_field("last_of_entry", 32'(want.last_of_entry),
                          32'(got.last_of_entry));
            compare_field("free_space", 32'(want.free_space), 32'(got.free_space));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
            compare_field("first_size", 32'(want.first_size), 32'(got.first_size));
        endfunction
    endclass

endpackage

// File: bench/tb_top.sv
// top of the length-prefixed message fifo bench: stimulus, reply capture and verdict
`timescale 1ns / 1ps

// drives request beats into the message fifo with random sender gaps, keeps a
// cycle-exact image of the byte ring in a tracker object and checks every
// result beat, field by field, against the oldest reply the tracker predicted
module tb_top;
    import lpmf_pkg::*;
    import lpmf_tb_pkg::*;

    // one beat per cycle and a registered result, so this is very generous
    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_BEATS  = 1200;
    localparam int SETTLE_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    req_code_t  req_type = REQ_RESET;
    logic [7:0] entry_len = 8'd0;
    logic [7:0] data_byte = 8'd0;
    logic       done;
    status_t    status;
    logic [7:0] read_byte;
    logic       last_of_entry;
    logic [8:0] free_space;
    logic [7:0] entry_count;
    logic [7:0] first_size;

    msg_ring_tracker ring_sb;
    int cycle_count = 0;

    length_prefixed_message_fifo dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .entry_len     (entry_len),
        .data_byte     (data_byte),
        .done          (done),
        .status        (status),
        .read_byte     (read_byte),
        .last_of_entry (last_of_entry),
        .free_space    (free_space),
        .entry_count   (entry_count),
        .first_size    (first_size)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // the receiver cannot stall, so every cycle with done high is a result beat
    always @(posedge clk)
    begin
        if (rst_n && done)
            ring_sb.check_reply({status, read_byte, last_of_entry, free_space,
                                 entry_count, first_size});
    end

    // hard stop in case the block hangs or never answers
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("length_prefixed_message_fifo test failed");
            $finish;
        end
    end

    // present one request beat and hold it until the block takes it; busy is
    // sampled before the edge updates it, so a low busy here means accepted
    task automatic send_req(req_code_t req, logic [7:0] len, logic [7:0] dat);
        start     <= 1'b1;
        req_type  <= req;
        entry_len <= len;
        data_byte <= dat;
        do
            @(posedge clk);
        while (busy);
        ring_sb.take_request(req, len, dat);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // sender stays quiet until every predicted reply has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (ring_sb.replies_due.size() != 0);
    endtask

    // mostly short messages, some medium ones, and now and then any size at all
    function automatic logic [7:0] pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 8'($urandom_range(0, 12));
        else if (roll < 90)
            return 8'($urandom_range(13, 60));
        return 8'($urandom_range(0, 255));
    endfunction

    // alternating fill and drain phases push the ring toward full, make the
    // pointers wrap and also empty the store now and then; pending data bytes
    // are mostly written right away so messages come out well formed
    task automatic run_random_traffic(int n_items);
        req_code_t  req;
        logic [7:0] len;
        logic [7:0] dat;
        int         roll;
        bit         filling;
        for (int i = 0; i < n_items; i++)
        begin
            filling = ((i / 120) % 2) == 0;
            len = pick_len();
            dat = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (ring_sb.wr_left != 0 && roll < 65)
                req = REQ_DATA;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < (filling ? 35 : 12))
                    req = REQ_START;
                else if (roll < (filling ? 42 : 16))
                    req = REQ_APPEND;
                else if (roll < 80)
                    req = REQ_READ;
                else if (roll < 90)
                    req = REQ_REMOVE;
                else if (roll < 95)
                    req = REQ_DATA;
                else if (roll < 98)
                    req = ($urandom_range(0, 1) != 0) ? REQ_NOP_A : REQ_NOP_B;
                else
                    req = REQ_RESET;
            end
            // a read that would hit a never written byte turns into a fill or a drop
            if (req == REQ_READ && !ring_sb.read_is_safe())
                req = (ring_sb.wr_left != 0) ? REQ_DATA : REQ_REMOVE;
            // at least once mid run the sender waits for all replies
            if (i == n_items / 2)
                wait_drained();
            // random sender gaps, none in the last fifth of the run
            if (i < n_items - n_items / 5 && $urandom_range(0, 9) == 0)
                hold_off($urandom_range(1, 19));
            send_req(req, len, dat);
        end
    endtask

    initial
    begin
        ring_sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty store corner cases
        send_req(REQ_READ, 8'd0, 8'd0);
        send_req(REQ_REMOVE, 8'd0, 8'd0);
        send_req(REQ_APPEND, 8'd5, 8'd0);
        send_req(REQ_DATA, 8'd0, 8'hFF);
        send_req(REQ_NOP_A, 8'hFF, 8'hFF);
        send_req(REQ_NOP_B, 8'd0, 8'd0);
        // zero length message, read back as a single empty beat
        send_req(REQ_START, 8'd0, 8'd0);
        send_req(REQ_READ, 8'd0, 8'd0);
        // size limits: 255 never fits, 254 fills the ring to one byte short
        send_req(REQ_START, 8'd255, 8'd0);
        send_req(REQ_START, 8'd254, 8'd0);
        send_req(REQ_APPEND, 8'd1, 8'd0);
        send_req(REQ_APPEND, 8'd0, 8'd0);
        // dropping the only message cancels its pending data
        send_req(REQ_REMOVE, 8'd0, 8'd0);
        send_req(REQ_DATA, 8'd0, 8'h00);
        // message grown by an append, then partly read
        send_req(REQ_START, 8'd2, 8'd0);
        send_req(REQ_DATA, 8'd0, 8'h00);
        send_req(REQ_DATA, 8'd0, 8'hFF);
        send_req(REQ_APPEND, 8'd1, 8'd0);
        send_req(REQ_DATA, 8'd0, 8'hA5);
        send_req(REQ_READ, 8'd0, 8'd0);
        // new message started while the previous one is still being filled
        send_req(REQ_START, 8'd3, 8'd0);
        send_req(REQ_DATA, 8'd0, 8'h5A);
        send_req(REQ_START, 8'd1, 8'd0);
        // remove after a partial read, then clear everything
        send_req(REQ_REMOVE, 8'd0, 8'd0);
        send_req(REQ_RESET, 8'd0, 8'd0);
        wait_drained();

        run_random_traffic(RANDOM_BEATS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ring_sb.errors == 0 && ring_sb.replies_due.size() == 0)
            $display("length_prefixed_message_fifo test passed");
        else
            $display("length_prefixed_message_fifo test failed");
        $finish;
    end

endmodule
